// ===== hw/rtl/odo_pkg.sv =====
`default_nettype none

package odo_pkg;

	// Field widths fixed by the item format
	localparam int HEADING_W = 12;
	localparam int ROM_ADDR_W = 10;
	localparam int MAG_W = 16;
	localparam int DPP_W = 16;
	localparam int CFG_W = 32;
	localparam int CFG_ADDR_W = 4;

	// Heading landmarks in tenths of a degree
	localparam logic [HEADING_W-1:0] HEADING_FULL = 12'd3600;
	localparam logic [HEADING_W-1:0] HEADING_QUARTER = 12'd900;
	localparam logic [HEADING_W-1:0] HEADING_HALF = 12'd1800;
	localparam logic [HEADING_W-1:0] HEADING_3QUARTER = 12'd2700;

	// Register map, indexed by paddr[3:2]
	localparam logic [1:0] REG_DPP = 2'd0;
	localparam logic [1:0] REG_START_X = 2'd1;
	localparam logic [1:0] REG_START_Y = 2'd2;

	localparam logic [DPP_W-1:0] DPP_RESET = 16'd4055;
	localparam logic signed [CFG_W-1:0] START_X_RESET = 32'sd6400;
	localparam logic signed [CFG_W-1:0] START_Y_RESET = 32'sd0;

	// Command kinds carried from front to back
	localparam logic [1:0] CMD_HOLD = 2'd0;
	localparam logic [1:0] CMD_UPDATE = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	typedef struct packed {
		logic neg;
		logic [ROM_ADDR_W-1:0] addr;
	} trig_ref_t;

	typedef struct packed {
		logic [1:0] kind;
		trig_ref_t cos_ref;
		trig_ref_t sin_ref;
	} cmd_t;

	// Fold a heading in 0..3599 onto the quarter-wave table
	function automatic trig_ref_t fold_heading(input logic [HEADING_W-1:0] h);
		trig_ref_t r;
		logic [HEADING_W-1:0] a;
		if (h <= HEADING_QUARTER) begin
			r.neg = 1'b0;
			a = h;
		end else if (h <= HEADING_HALF) begin
			r.neg = 1'b0;
			a = HEADING_HALF - h;
		end else if (h <= HEADING_3QUARTER) begin
			r.neg = 1'b1;
			a = h - HEADING_HALF;
		end else begin
			r.neg = 1'b1;
			a = HEADING_FULL - h;
		end
		r.addr = a[ROM_ADDR_W-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/odo_in_if.sv =====
`default_nettype none

interface odo_in_if;
	logic valid;
	logic ready;
	logic left_pulse;
	logic right_pulse;
	logic update;
	logic [11:0] heading;
	logic restart;

	modport source (output valid, output left_pulse, output right_pulse, output update,
		output heading, output restart, input ready);
	modport sink (input valid, input left_pulse, input right_pulse, input update,
		input heading, input restart, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/odo_out_if.sv =====
`default_nettype none

interface odo_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;

	modport source (output valid, output pos_x, output pos_y, input ready);
	modport sink (input valid, input pos_x, input pos_y, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/odo_fifo.sv =====
`default_nettype none

module odo_fifo #(
	parameter int DATA_W = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic [DATA_W-1:0] push_data,
	input wire logic pop,
	output logic [DATA_W-1:0] head_data,
	output logic full,
	output logic empty
);
	logic [DATA_W-1:0] mem_q [0:1];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end
endmodule

`default_nettype wire

// ===== hw/rtl/odo_front.sv =====
`default_nettype none

module odo_front #(
	parameter int COUNT_WIDTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	odo_in_if.sink items,
	input wire logic queue_full,
	output logic push,
	output odo_pkg::cmd_t cmd,
	output logic [COUNT_WIDTH:0] sum
);
	import odo_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	logic [COUNT_WIDTH-1:0] left_q;
	logic [COUNT_WIDTH-1:0] right_q;
	logic [COUNT_WIDTH-1:0] left_next;
	logic [COUNT_WIDTH-1:0] right_next;
	logic [HEADING_W-1:0] h_wrap;
	logic [HEADING_W:0] h_cos_raw;
	logic [HEADING_W-1:0] h_cos;

	assign items.ready = !queue_full;
	assign push = items.valid && items.ready;

	// Saturating pulse counts, dropping an edge at the top
	assign left_next = (items.left_pulse && left_q != CNT_MAX) ? left_q + 1'b1 : left_q;
	assign right_next = (items.right_pulse && right_q != CNT_MAX) ? right_q + 1'b1 : right_q;
	assign sum = (COUNT_WIDTH + 1)'(left_next) + (COUNT_WIDTH + 1)'(right_next);

	always_comb begin
		h_wrap = (items.heading >= HEADING_FULL) ? items.heading - HEADING_FULL : items.heading;
		h_cos_raw = {1'b0, h_wrap} + {1'b0, HEADING_QUARTER};
		if (h_cos_raw >= {1'b0, HEADING_FULL}) begin
			h_cos_raw = h_cos_raw - {1'b0, HEADING_FULL};
		end
		h_cos = h_cos_raw[HEADING_W-1:0];

		priority if (items.restart) begin
			cmd.kind = CMD_RESTART;
		end else if (items.update) begin
			cmd.kind = CMD_UPDATE;
		end else begin
			cmd.kind = CMD_HOLD;
		end
		cmd.sin_ref = fold_heading(h_wrap);
		cmd.cos_ref = fold_heading(h_cos);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			right_q <= '0;
		end else if (push) begin
			if (items.restart || items.update) begin
				left_q <= '0;
				right_q <= '0;
			end else begin
				left_q <= left_next;
				right_q <= right_next;
			end
		end
	end
endmodule

`default_nettype wire

// ===== hw/rtl/odo_back.sv =====
`default_nettype none

module odo_back #(
	parameter int COUNT_WIDTH = 16,
	parameter int POS_WIDTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [odo_pkg::DPP_W-1:0] dpp,
	input wire logic signed [odo_pkg::CFG_W-1:0] start_x,
	input wire logic signed [odo_pkg::CFG_W-1:0] start_y,
	input wire logic queue_empty,
	input wire odo_pkg::cmd_t head_cmd,
	input wire logic [COUNT_WIDTH:0] head_sum,
	output logic pop,
	odo_out_if.source results
);
	import odo_pkg::*;

	localparam int SINE_DEPTH = 901;
	localparam int SUM_W = COUNT_WIDTH + 1;
	localparam int PROD1_W = SUM_W + DPP_W;
	localparam int PROD2_W = PROD1_W + MAG_W;
	localparam int DELTA_W = PROD2_W - 24 + 2;
	localparam int WIDE_A = (POS_WIDTH > DELTA_W) ? POS_WIDTH : DELTA_W;
	localparam int WIDE_B = (WIDE_A > CFG_W) ? WIDE_A : CFG_W;
	localparam int SW = WIDE_B + 1;

	localparam logic signed [SW-1:0] POS_HI = signed'(SW'({(POS_WIDTH - 1){1'b1}}));
	localparam logic signed [SW-1:0] POS_LO = ~POS_HI;

	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'd1073741824;

	typedef logic [SINE_DEPTH-1:0][MAG_W-1:0] sine_rom_t;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL = 3'd1;
	localparam logic [2:0] ST_MULX = 3'd2;
	localparam logic [2:0] ST_MULY = 3'd3;
	localparam logic [2:0] ST_ADDX = 3'd4;
	localparam logic [2:0] ST_ADDY = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	// Q1.15 sine per tenth of a degree, from a fixed Q30 Taylor series
	function automatic logic [MAG_W-1:0] sine_entry(input logic [63:0] a);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		x = (a * PI_Q30) / 64'd1800;
		x2 = (x * x) >> 30;
		t = ONE_Q30 - x2 / 64'd110;
		t = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
		t = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
		t = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
		t = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
		s = (x * t) >> 30;
		s = (s + 64'd16384) >> 15;
		if (s > 64'd32768) begin
			s = 64'd32768;
		end
		return s[MAG_W-1:0];
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t r;
		for (int i = 0; i < SINE_DEPTH; i++) begin
			r[i] = sine_entry(64'(i));
		end
		return r;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	function automatic logic signed [POS_WIDTH-1:0] sat_pos(input logic signed [SW-1:0] v);
		logic signed [POS_WIDTH-1:0] r;
		if (v > POS_HI) begin
			r = POS_HI[POS_WIDTH-1:0];
		end else if (v < POS_LO) begin
			r = POS_LO[POS_WIDTH-1:0];
		end else begin
			r = v[POS_WIDTH-1:0];
		end
		return r;
	endfunction

	// Round half away from zero, then apply the sign
	function automatic logic signed [SW-1:0] round_delta(input logic [PROD2_W-1:0] p,
		input logic neg);
		logic [PROD2_W:0] r;
		logic signed [SW-1:0] q;
		r = {1'b0, p} + (PROD2_W + 1)'(1 << 23);
		q = signed'(SW'(r[PROD2_W:24]));
		return neg ? -q : q;
	endfunction

	logic [2:0] state_q;
	cmd_t cmd_q;
	logic [SUM_W-1:0] sum_q;
	logic [PROD1_W-1:0] dist_q;
	logic [PROD2_W-1:0] mul_x_q;
	logic [PROD2_W-1:0] mul_y_q;
	logic signed [SW-1:0] dx_q;
	logic signed [SW-1:0] dy_q;
	logic [MAG_W-1:0] rom_q;
	logic [ROM_ADDR_W-1:0] rom_addr;
	logic signed [POS_WIDTH-1:0] pos_x_q;
	logic signed [POS_WIDTH-1:0] pos_y_q;
	logic out_v_q;
	logic signed [31:0] out_x_q;
	logic signed [31:0] out_y_q;
	logic out_load;

	assign pop = (state_q == ST_IDLE) && !queue_empty;
	assign out_load = (state_q == ST_DONE) && (!out_v_q || results.ready);
	assign rom_addr = (state_q == ST_MUL) ? cmd_q.cos_ref.addr : cmd_q.sin_ref.addr;

	assign results.valid = out_v_q;
	assign results.pos_x = out_x_q;
	assign results.pos_y = out_y_q;

	always_ff @(posedge clk) begin
		rom_q <= SINE_ROM[rom_addr];
		if (pop) begin
			cmd_q <= head_cmd;
			sum_q <= head_sum;
		end
		dist_q <= PROD1_W'(sum_q) * PROD1_W'(dpp);
		mul_x_q <= PROD2_W'(dist_q) * PROD2_W'(rom_q);
		mul_y_q <= PROD2_W'(dist_q) * PROD2_W'(rom_q);
		dx_q <= round_delta(mul_x_q, cmd_q.cos_ref.neg);
		dy_q <= round_delta(mul_y_q, cmd_q.sin_ref.neg);
		if (out_load) begin
			out_x_q <= 32'(pos_x_q);
			out_y_q <= 32'(pos_y_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
			pos_x_q <= POS_WIDTH'(START_X_RESET);
			pos_y_q <= POS_WIDTH'(START_Y_RESET);
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (results.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						priority if (head_cmd.kind == CMD_RESTART) begin
							pos_x_q <= sat_pos(SW'(start_x));
							pos_y_q <= sat_pos(SW'(start_y));
							state_q <= ST_DONE;
						end else if (head_cmd.kind == CMD_UPDATE) begin
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_MUL: state_q <= ST_MULX;
				ST_MULX: state_q <= ST_MULY;
				ST_MULY: state_q <= ST_ADDX;
				ST_ADDX: begin
					pos_x_q <= sat_pos(SW'(pos_x_q) + dx_q);
					state_q <= ST_ADDY;
				end
				ST_ADDY: begin
					pos_y_q <= sat_pos(SW'(pos_y_q) + dy_q);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

`default_nettype wire

// ===== hw/rtl/wheel_compass_odometry_unit.sv =====
`default_nettype none

// Dead-reckoning odometry unit. Each item on the items channel may carry a
// left and a right encoder edge, an update request with a compass heading in
// tenths of a degree, and a restart flag; every item yields exactly one
// transfer on the results channel with the X and Y position (1/128 cm, signed)
// after that item. Edges accumulate in saturating pulse counters; an update
// moves the position by (left+right) * distance_per_pulse * cos/sin(heading),
// rounded to the nearest 1/128 cm, saturates at the signed POS_WIDTH limits and
// clears the counters; restart reloads start_x/start_y and clears the counters.
// Headings of 3600 and above wrap. A front stage counts edges and classifies
// each item in the cycle it is accepted, then hands it through a two-entry
// queue to a sequencer that does the arithmetic, so the front keeps accepting
// while the back is busy or a result waits, until the queue is full. Updates
// step the back end through MUL, MULX, MULY, ADDX, ADDY (one registered sine
// table port read twice, then three dependent multiply/round/add steps), other
// items go from IDLE to DONE; this sequencer sets the throughput and pops an
// item only after the last result is loaded. APB registers: 0x0 distance_per_pulse
// (Q0.16 cm), 0x4 start_x, 0x8 start_y; write them only while the unit is idle.
module wheel_compass_odometry_unit #(
	parameter int COUNT_WIDTH = 16,
	parameter int POS_WIDTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	odo_in_if.sink items,
	odo_out_if.source results,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [odo_pkg::CFG_ADDR_W-1:0] paddr,
	input wire logic [odo_pkg::CFG_W-1:0] pwdata,
	output logic [odo_pkg::CFG_W-1:0] prdata,
	output logic pready
);
	import odo_pkg::*;

	localparam int QUEUE_W = $bits(cmd_t) + COUNT_WIDTH + 1;

	logic [DPP_W-1:0] dpp_q;
	logic signed [CFG_W-1:0] start_x_q;
	logic signed [CFG_W-1:0] start_y_q;
	logic cfg_write;
	logic [1:0] reg_idx;

	logic queue_full;
	logic queue_empty;
	logic push;
	logic pop;
	cmd_t front_cmd;
	cmd_t head_cmd;
	logic [COUNT_WIDTH:0] front_sum;
	logic [COUNT_WIDTH:0] head_sum;
	logic [QUEUE_W-1:0] head_data;

	// APB: zero wait states, write on the access phase
	assign pready = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx)
			REG_DPP: prdata = CFG_W'(dpp_q);
			REG_START_X: prdata = start_x_q;
			REG_START_Y: prdata = start_y_q;
			default: prdata = '0;
		endcase
	end

	// Writes to unmapped slots drop silently
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpp_q <= DPP_RESET;
			start_x_q <= START_X_RESET;
			start_y_q <= START_Y_RESET;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_DPP: dpp_q <= pwdata[DPP_W-1:0];
				REG_START_X: start_x_q <= pwdata;
				REG_START_Y: start_y_q <= pwdata;
				default: ;
			endcase
		end
	end

	// Front: count edges, classify, fold the heading onto the quarter-wave table
	odo_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.items(items),
		.queue_full(queue_full),
		.push(push),
		.cmd(front_cmd),
		.sum(front_sum)
	);

	// Hold classified items until the back end is free
	odo_fifo #(
		.DATA_W(QUEUE_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data({front_cmd, front_sum}),
		.pop(pop),
		.head_data(head_data),
		.full(queue_full),
		.empty(queue_empty)
	);

	assign head_cmd = head_data[QUEUE_W-1:COUNT_WIDTH+1];
	assign head_sum = head_data[COUNT_WIDTH:0];

	// Back: integrate position and present the result
	odo_back #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.POS_WIDTH(POS_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.dpp(dpp_q),
		.start_x(start_x_q),
		.start_y(start_y_q),
		.queue_empty(queue_empty),
		.head_cmd(head_cmd),
		.head_sum(head_sum),
		.pop(pop),
		.results(results)
	);
endmodule

`default_nettype wire
